// File: rtl/bqws_pkg.sv
package bqws_pkg;

  // field widths of the item ports
  localparam int X_W   = 10;
  localparam int Y_W   = 9;
  localparam int PIX_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_C0X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C0Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C1X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C1Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C2X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C2Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_C3X = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_C3Y = 4'd7;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // q0.16 weight arithmetic
  localparam int FRAC_W  = 16;
  localparam int WT_W    = FRAC_W + 1;
  localparam logic [WT_W-1:0] ONE_Q16 = 17'h10000;
  // reciprocal multiply: shift, reciprocal width and remainder width
  localparam int RSH     = 12;
  localparam int RECIP_W = FRAC_W + RSH;
  localparam int REM_W   = 30;
  // row blend widths (corner * weight sums)
  localparam int AX_W    = X_W + FRAC_W;
  localparam int AY_W    = Y_W + FRAC_W;
  // column blend widths before the final shift
  localparam int SXF_W   = AX_W + FRAC_W;
  localparam int SYF_W   = AY_W + FRAC_W;

  // item handed from the front to the back
  typedef struct packed {
    logic             is_read;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [PIX_W-1:0] pix;
  } fe_item_t;

  // result word
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [X_W-1:0]   src_x;
    logic [Y_W-1:0]   src_y;
    logic             clip;
  } out_item_t;

  // quad corners
  typedef struct packed {
    logic [X_W-1:0] c0x;
    logic [Y_W-1:0] c0y;
    logic [X_W-1:0] c1x;
    logic [Y_W-1:0] c1y;
    logic [X_W-1:0] c2x;
    logic [Y_W-1:0] c2y;
    logic [X_W-1:0] c3x;
    logic [Y_W-1:0] c3y;
  } corner_cfg_t;

endpackage

// File: rtl/bqws_fifo.sv
module bqws_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));

endmodule

// File: rtl/bqws_front.sv
module bqws_front #(
  parameter int WIDTH  = 640,
  parameter int HEIGHT = 480
) (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [bqws_pkg::X_W-1:0]     pos_x_i,
  input  logic [bqws_pkg::Y_W-1:0]     pos_y_i,
  input  logic [bqws_pkg::PIX_W-1:0]   pixel_in_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output bqws_pkg::fe_item_t           item_o
);

  logic is_read;
  logic x_over;
  logic y_over;
  logic drop;

  // classify: reads get saturated coordinates, writes outside the frame vanish
  always_comb begin
    is_read = (cmd_i == bqws_pkg::CMD_READ);
    x_over  = int'(pos_x_i) > WIDTH - 1;
    y_over  = int'(pos_y_i) > HEIGHT - 1;
    drop    = !is_read && (x_over || y_over);

    item_o.is_read = is_read;
    item_o.x       = (is_read && x_over) ? bqws_pkg::X_W'(WIDTH - 1) : pos_x_i;
    item_o.y       = (is_read && y_over) ? bqws_pkg::Y_W'(HEIGHT - 1) : pos_y_i;
    item_o.pix     = pixel_in_i;
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && !drop;

endmodule

// File: rtl/bqws_back.sv
module bqws_back #(
  parameter int WIDTH     = 640,
  parameter int HEIGHT    = 480,
  parameter int OUT_DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bqws_pkg::corner_cfg_t  corners_i,
  input  logic                   q_valid_i,
  input  bqws_pkg::fe_item_t     q_item_i,
  output logic                   q_pop_o,
  input  logic                   out_accept_i,
  output logic                   push_o,
  output bqws_pkg::out_item_t    item_o
);

  localparam int NSTG  = 7;
  localparam int DEPTH = WIDTH * HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RES_W = $clog2(OUT_DEPTH + 1);
  localparam int PX_W  = bqws_pkg::X_W + bqws_pkg::RECIP_W;
  localparam int PY_W  = bqws_pkg::Y_W + bqws_pkg::RECIP_W;
  localparam logic [bqws_pkg::RECIP_W-1:0] RECIP_X =
    bqws_pkg::RECIP_W'((64'd1 << (bqws_pkg::FRAC_W + bqws_pkg::RSH)) / WIDTH);
  localparam logic [bqws_pkg::RECIP_W-1:0] RECIP_Y =
    bqws_pkg::RECIP_W'((64'd1 << (bqws_pkg::FRAC_W + bqws_pkg::RSH)) / HEIGHT);

  logic [NSTG-1:0]    vld_q, vld_d;
  logic [RES_W-1:0]   res_q, res_d;
  logic               pop;

  bqws_pkg::fe_item_t m0_q, m1_q, m2_q, m3_q, m4_q;

  logic [PX_W-1:0]                  prod_x;
  logic [PY_W-1:0]                  prod_y;
  logic [bqws_pkg::FRAC_W-1:0]      qx_q, qy_q;
  logic [bqws_pkg::REM_W-1:0]       rem_x, rem_y;
  logic [bqws_pkg::FRAC_W-1:0]      u_d, v_d, u_q, v_q, u3_q, v3_q;
  logic [bqws_pkg::WT_W-1:0]        bu2, bv2, bu3, bv3;
  logic [bqws_pkg::AX_W-1:0]        ax_d, bx_d, ax_q, bx_q;
  logic [bqws_pkg::AY_W-1:0]        ay_d, by_d, ay_q, by_q;
  logic [bqws_pkg::SXF_W-1:0]       sum_x;
  logic [bqws_pkg::SYF_W-1:0]       sum_y;
  logic [bqws_pkg::X_W-1:0]         sx_q;
  logic [bqws_pkg::Y_W-1:0]         sy_q;
  logic                             clip_x, clip_y;
  logic [bqws_pkg::X_W-1:0]         sxc, col;
  logic [bqws_pkg::Y_W-1:0]         syc, row;
  logic [AW-1:0]                    addr_d, addr_q;
  logic                             rd5_q, clip5_q, wen;
  logic [bqws_pkg::PIX_W-1:0]       pix5_q;
  logic [bqws_pkg::X_W-1:0]         sx5_q, sx6_q;
  logic [bqws_pkg::Y_W-1:0]         sy5_q, sy6_q;
  logic                             rd6_q, clip6_q;
  logic [bqws_pkg::PIX_W-1:0]       rdata_q;
  logic [bqws_pkg::PIX_W-1:0]       frame_mem [DEPTH];

  // issue: writes always go, reads need a reserved slot in the result fifo
  assign pop = q_valid_i && (!q_item_i.is_read || res_q < RES_W'(OUT_DEPTH));
  assign q_pop_o = pop;

  always_comb begin
    res_d = res_q + RES_W'(pop && q_item_i.is_read) - RES_W'(out_accept_i);
    vld_d = {vld_q[NSTG-2:0], pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      res_q <= '0;
    end else begin
      vld_q <= vld_d;
      res_q <= res_d;
    end
  end

  // stage 1: quotient estimate of x*65536/WIDTH by reciprocal multiply
  assign prod_x = PX_W'(m0_q.x) * PX_W'(RECIP_X);
  assign prod_y = PY_W'(m0_q.y) * PY_W'(RECIP_Y);

  // stage 2: one-step correction of the estimate
  always_comb begin
    rem_x = bqws_pkg::REM_W'({m1_q.x, {bqws_pkg::FRAC_W{1'b0}}})
          - bqws_pkg::REM_W'(qx_q) * bqws_pkg::REM_W'(WIDTH);
    rem_y = bqws_pkg::REM_W'({m1_q.y, {bqws_pkg::FRAC_W{1'b0}}})
          - bqws_pkg::REM_W'(qy_q) * bqws_pkg::REM_W'(HEIGHT);
    u_d = qx_q + bqws_pkg::FRAC_W'(rem_x >= bqws_pkg::REM_W'(WIDTH));
    v_d = qy_q + bqws_pkg::FRAC_W'(rem_y >= bqws_pkg::REM_W'(HEIGHT));
  end

  // stage 3: first blend along the edges
  always_comb begin
    bu2  = bqws_pkg::ONE_Q16 - bqws_pkg::WT_W'(u_q);
    bv2  = bqws_pkg::ONE_Q16 - bqws_pkg::WT_W'(v_q);
    ax_d = bqws_pkg::AX_W'(corners_i.c0x) * bqws_pkg::AX_W'(bu2)
         + bqws_pkg::AX_W'(corners_i.c1x) * bqws_pkg::AX_W'(u_q);
    bx_d = bqws_pkg::AX_W'(corners_i.c3x) * bqws_pkg::AX_W'(bu2)
         + bqws_pkg::AX_W'(corners_i.c2x) * bqws_pkg::AX_W'(u_q);
    ay_d = bqws_pkg::AY_W'(corners_i.c0y) * bqws_pkg::AY_W'(bv2)
         + bqws_pkg::AY_W'(corners_i.c3y) * bqws_pkg::AY_W'(v_q);
    by_d = bqws_pkg::AY_W'(corners_i.c1y) * bqws_pkg::AY_W'(bv2)
         + bqws_pkg::AY_W'(corners_i.c2y) * bqws_pkg::AY_W'(v_q);
  end

  // stage 4: second blend, keep the integer part
  always_comb begin
    bu3   = bqws_pkg::ONE_Q16 - bqws_pkg::WT_W'(u3_q);
    bv3   = bqws_pkg::ONE_Q16 - bqws_pkg::WT_W'(v3_q);
    sum_x = bqws_pkg::SXF_W'(ax_q) * bqws_pkg::SXF_W'(bv3)
          + bqws_pkg::SXF_W'(bx_q) * bqws_pkg::SXF_W'(v3_q);
    sum_y = bqws_pkg::SYF_W'(ay_q) * bqws_pkg::SYF_W'(bu3)
          + bqws_pkg::SYF_W'(by_q) * bqws_pkg::SYF_W'(u3_q);
  end

  // stage 5: clamp into the frame and form the frame store address
  always_comb begin
    clip_x = int'(sx_q) > WIDTH - 1;
    clip_y = int'(sy_q) > HEIGHT - 1;
    sxc    = clip_x ? bqws_pkg::X_W'(WIDTH - 1) : sx_q;
    syc    = clip_y ? bqws_pkg::Y_W'(HEIGHT - 1) : sy_q;
    col    = m4_q.is_read ? sxc : m4_q.x;
    row    = m4_q.is_read ? syc : m4_q.y;
    addr_d = AW'(row) * AW'(WIDTH) + AW'(col);
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    m0_q    <= q_item_i;
    m1_q    <= m0_q;
    qx_q    <= prod_x[bqws_pkg::RSH+bqws_pkg::FRAC_W-1:bqws_pkg::RSH];
    qy_q    <= prod_y[bqws_pkg::RSH+bqws_pkg::FRAC_W-1:bqws_pkg::RSH];
    m2_q    <= m1_q;
    u_q     <= u_d;
    v_q     <= v_d;
    m3_q    <= m2_q;
    ax_q    <= ax_d;
    bx_q    <= bx_d;
    ay_q    <= ay_d;
    by_q    <= by_d;
    u3_q    <= u_q;
    v3_q    <= v_q;
    m4_q    <= m3_q;
    sx_q    <= sum_x[2*bqws_pkg::FRAC_W+bqws_pkg::X_W-1:2*bqws_pkg::FRAC_W];
    sy_q    <= sum_y[2*bqws_pkg::FRAC_W+bqws_pkg::Y_W-1:2*bqws_pkg::FRAC_W];
    addr_q  <= addr_d;
    rd5_q   <= m4_q.is_read;
    pix5_q  <= m4_q.pix;
    sx5_q   <= sxc;
    sy5_q   <= syc;
    clip5_q <= clip_x || clip_y;
    rd6_q   <= rd5_q;
    sx6_q   <= sx5_q;
    sy6_q   <= sy5_q;
    clip6_q <= clip5_q;
  end

  // stage 6: frame store, one access per cycle in item order
  assign wen = vld_q[5] && !rd5_q;

  always_ff @(posedge clk_i) begin
    if (wen) begin
      frame_mem[addr_q] <= pix5_q;
    end
    rdata_q <= frame_mem[addr_q];
  end

  // result word
  assign push_o       = vld_q[6] && rd6_q;
  assign item_o.pix   = rdata_q;
  assign item_o.src_x = sx6_q;
  assign item_o.src_y = sy6_q;
  assign item_o.clip  = clip6_q;

endmodule

// File: rtl/bilinear_quad_warp_sampler_unit.sv
// Quad warp sampler over an on-chip 8-bit frame store of WIDTH x HEIGHT pixels.
// A write word (cmd 0) stores pixel_in at (pos_x, pos_y); writes outside the
// frame are dropped and no write gives a result. A read word (cmd 1) maps the
// output position into the quad set by the corner registers with q0.16 bilinear
// weights and returns the source pixel at the truncated position, its
// clamped source coordinates and a clipped flag. One word is accepted per
// clock when neither side stalls; a read result passes the seven weight and
// address pipeline stages and the result fifo write on its way to the output,
// plus any wait behind earlier words that are still held in the input
// queue. Reads and writes reach the frame store in acceptance order, so a read
// always sees every earlier write. Reading a pixel never written since reset
// returns undefined data. Corner registers may be written only while the block
// is idle.
module bilinear_quad_warp_sampler_unit #(
  parameter int WIDTH       = 640,
  parameter int HEIGHT      = 480,
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [bqws_pkg::X_W-1:0]          pos_x_i,
  input  logic [bqws_pkg::Y_W-1:0]          pos_y_i,
  input  logic [bqws_pkg::PIX_W-1:0]        pixel_in_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bqws_pkg::PIX_W-1:0]        pixel_out_o,
  output logic [bqws_pkg::X_W-1:0]          src_x_o,
  output logic [bqws_pkg::Y_W-1:0]          src_y_o,
  output logic                              clipped_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bqws_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bqws_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  bqws_pkg::corner_cfg_t corners_q;
  bqws_pkg::fe_item_t    fe_item, q_item;
  bqws_pkg::out_item_t   bk_item, of_item;
  logic                  fe_push, q_full, q_empty, q_pop;
  logic                  bk_push, of_empty, of_full, out_accept;

  // corner registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corners_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bqws_pkg::REG_C0X: corners_q.c0x <= cfg_data_i;
        bqws_pkg::REG_C0Y: corners_q.c0y <= cfg_data_i[bqws_pkg::Y_W-1:0];
        bqws_pkg::REG_C1X: corners_q.c1x <= cfg_data_i;
        bqws_pkg::REG_C1Y: corners_q.c1y <= cfg_data_i[bqws_pkg::Y_W-1:0];
        bqws_pkg::REG_C2X: corners_q.c2x <= cfg_data_i;
        bqws_pkg::REG_C2Y: corners_q.c2y <= cfg_data_i[bqws_pkg::Y_W-1:0];
        bqws_pkg::REG_C3X: corners_q.c3x <= cfg_data_i;
        bqws_pkg::REG_C3Y: corners_q.c3y <= cfg_data_i[bqws_pkg::Y_W-1:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  bqws_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pixel_in_i (pixel_in_i),
    .q_full_i   (q_full),
    .push_o     (fe_push),
    .item_o     (fe_item)
  );

  // queue between front and back
  bqws_fifo #(
    .DW    ($bits(bqws_pkg::fe_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_item),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: weights, mapping, frame store
  bqws_back #(
    .WIDTH     (WIDTH),
    .HEIGHT    (HEIGHT),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .corners_i    (corners_q),
    .q_valid_i    (!q_empty),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_accept_i (out_accept),
    .push_o       (bk_push),
    .item_o       (bk_item)
  );

  // result fifo
  bqws_fifo #(
    .DW    ($bits(bqws_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_push),
    .data_i  (bk_item),
    .pop_i   (out_accept),
    .data_o  (of_item),
    .empty_o (of_empty),
    .full_o  (of_full)
  );

  assign out_valid_o = !of_empty;
  assign out_accept  = out_valid_o && !out_stall_i;
  assign pixel_out_o = of_item.pix;
  assign src_x_o     = of_item.src_x;
  assign src_y_o     = of_item.src_y;
  assign clipped_o   = of_item.clip;

`ifndef NO_ASSERTIONS
  // slot reservation must keep the result fifo from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni) bk_push |-> !of_full)
    else $error("result fifo overflow");

  // a clipped result sits on the frame border
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (int'(src_x_o) == WIDTH - 1 || int'(src_y_o) == HEIGHT - 1))
    else $error("clipped result not on frame border");

  // source coordinates stay inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(src_x_o) < WIDTH && int'(src_y_o) < HEIGHT))
    else $error("source coordinate outside frame");
`endif

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqws_pkg::*;

  localparam int FRAME_W       = 640;
  localparam int FRAME_H       = 480;
  localparam int FRAME_PIXELS  = FRAME_W * FRAME_H;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;
  localparam int LONG_HOLD     = 150;
  localparam int X_MAX         = (1 << X_W) - 1;
  localparam int Y_MAX         = (1 << Y_W) - 1;
  localparam int DATA_MAX      = (1 << CFG_DATA_W) - 1;
  localparam longint unsigned Q16_ONE = 64'd65536;
  // indexes past the last corner register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  cmd_i       = CMD_WRITE;
  logic [X_W-1:0]        pos_x_i     = '0;
  logic [Y_W-1:0]        pos_y_i     = '0;
  logic [PIX_W-1:0]      pixel_in_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      pixel_out_o;
  logic [X_W-1:0]        src_x_o;
  logic [Y_W-1:0]        src_y_o;
  logic                  clipped_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // predictor state: corners and a copy of the frame store
  logic [X_W-1:0]   corner_x [4];
  logic [Y_W-1:0]   corner_y [4];
  logic [PIX_W-1:0] frame_copy [FRAME_PIXELS];
  bit               written_map [FRAME_PIXELS];
  out_item_t        expected_samples [$];

  // idling controls
  bit tx_gaps_on     = 1'b0;
  bit rx_gaps_on     = 1'b0;
  int rx_hold_cycles = 0;
  int rx_burst       = 0;
  int quiet_cycles   = 0;

  // tallies
  int mismatches      = 0;
  int results_checked = 0;
  int reads_sent      = 0;
  int clipped_reads   = 0;
  int writes_stored   = 0;
  int writes_dropped  = 0;
  int reg_writes      = 0;
  int quad_settings   = 0;

  bilinear_quad_warp_sampler_unit #(
    .WIDTH (FRAME_W),
    .HEIGHT(FRAME_H)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pixel_in_i (pixel_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pixel_out_o(pixel_out_o),
    .src_x_o    (src_x_o),
    .src_y_o    (src_y_o),
    .clipped_o  (clipped_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // q0.16 linear blend, kept exact in 64 bits
  function automatic longint unsigned lerp_q16(input longint unsigned a,
                                               input longint unsigned b,
                                               input longint unsigned w);
    return a * (Q16_ONE - w) + b * w;
  endfunction

  // output position to clamped source position under the current quad
  function automatic void map_to_source(input logic [X_W-1:0] ox, input logic [Y_W-1:0] oy,
                                        output logic [X_W-1:0] sx,
                                        output logic [Y_W-1:0] sy,
                                        output logic clip);
    longint unsigned px, py, u, v, fx, fy;
    px = (ox > FRAME_W - 1) ? FRAME_W - 1 : ox;
    py = (oy > FRAME_H - 1) ? FRAME_H - 1 : oy;
    u = px * Q16_ONE / FRAME_W;
    v = py * Q16_ONE / FRAME_H;
    fx = lerp_q16(lerp_q16(corner_x[0], corner_x[1], u),
                  lerp_q16(corner_x[3], corner_x[2], u), v) >> 32;
    fy = lerp_q16(lerp_q16(corner_y[0], corner_y[3], v),
                  lerp_q16(corner_y[1], corner_y[2], v), u) >> 32;
    clip = 1'b0;
    if (fx > FRAME_W - 1) begin
      fx = FRAME_W - 1;
      clip = 1'b1;
    end
    if (fy > FRAME_H - 1) begin
      fy = FRAME_H - 1;
      clip = 1'b1;
    end
    sx = fx[X_W-1:0];
    sy = fy[Y_W-1:0];
  endfunction

  // update the frame copy or predict the sample for one accepted word
  function automatic void apply_word(input logic cmd, input logic [X_W-1:0] x,
                                     input logic [Y_W-1:0] y, input logic [PIX_W-1:0] pix);
    int             addr;
    logic [X_W-1:0] sx;
    logic [Y_W-1:0] sy;
    logic           clip;
    out_item_t      want;
    if (cmd == CMD_WRITE) begin
      if (x < FRAME_W && y < FRAME_H) begin
        addr = int'(y) * FRAME_W + int'(x);
        frame_copy[addr] = pix;
        written_map[addr] = 1'b1;
        writes_stored++;
      end else begin
        writes_dropped++;
      end
    end else begin
      map_to_source(x, y, sx, sy, clip);
      want.pix   = frame_copy[int'(sy) * FRAME_W + int'(sx)];
      want.src_x = sx;
      want.src_y = sy;
      want.clip  = clip;
      expected_samples.push_back(want);
      reads_sent++;
      if (clip) clipped_reads++;
    end
  endfunction

  // offer one word from a falling edge, return at a falling edge after it is taken
  task automatic send_word(input logic cmd, input logic [X_W-1:0] x,
                           input logic [Y_W-1:0] y, input logic [PIX_W-1:0] pix);
    int gap;
    cmd_i      = cmd;
    pos_x_i    = x;
    pos_y_i    = y;
    pixel_in_i = pix;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_word(cmd, x, y, pix);
    @(negedge clk_i);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // read an output pixel, writing its source pixel first when unknown or, if allowed, at random
  task automatic read_sample(input logic [X_W-1:0] ox, input logic [Y_W-1:0] oy,
                             input bit may_rewrite);
    logic [X_W-1:0] sx;
    logic [Y_W-1:0] sy;
    logic           clip;
    map_to_source(ox, oy, sx, sy, clip);
    if (!written_map[int'(sy) * FRAME_W + int'(sx)] ||
        (may_rewrite && $urandom_range(0, 3) == 0))
      send_word(CMD_WRITE, sx, sy, PIX_W'($urandom_range(0, 255)));
    send_word(CMD_READ, ox, oy, PIX_W'($urandom_range(0, 255)));
  endtask

  // hold the input until every predicted sample is back and the pipe is empty
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_C0X: corner_x[0] = data;
      REG_C0Y: corner_y[0] = data[Y_W-1:0];
      REG_C1X: corner_x[1] = data;
      REG_C1Y: corner_y[1] = data[Y_W-1:0];
      REG_C2X: corner_x[2] = data;
      REG_C2Y: corner_y[2] = data[Y_W-1:0];
      REG_C3X: corner_x[3] = data;
      REG_C3Y: corner_y[3] = data[Y_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_quad(input logic [CFG_DATA_W-1:0] x0, input logic [CFG_DATA_W-1:0] y0,
                          input logic [CFG_DATA_W-1:0] x1, input logic [CFG_DATA_W-1:0] y1,
                          input logic [CFG_DATA_W-1:0] x2, input logic [CFG_DATA_W-1:0] y2,
                          input logic [CFG_DATA_W-1:0] x3, input logic [CFG_DATA_W-1:0] y3);
    wait_drained();
    write_reg(REG_C0X, x0);
    write_reg(REG_C0Y, y0);
    write_reg(REG_C1X, x1);
    write_reg(REG_C1Y, y1);
    write_reg(REG_C2X, x2);
    write_reg(REG_C2Y, y2);
    write_reg(REG_C3X, x3);
    write_reg(REG_C3Y, y3);
    quad_settings++;
  endtask

  // style 0 picks from 0 to span, at most one past the frame, 1 spans the whole register, 2 picks extremes
  function automatic logic [CFG_DATA_W-1:0] pick_corner(input int style, input int span);
    case (style)
      0: return CFG_DATA_W'($urandom_range(0, span));
      1: return CFG_DATA_W'($urandom_range(0, DATA_MAX));
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return CFG_DATA_W'(span);
          default: return CFG_DATA_W'(DATA_MAX);
        endcase
      end
    endcase
  endfunction

  task automatic program_random_quad(input int style);
    set_quad(pick_corner(style, FRAME_W), pick_corner(style, FRAME_H),
             pick_corner(style, FRAME_W), pick_corner(style, FRAME_H),
             pick_corner(style, FRAME_W), pick_corner(style, FRAME_H),
             pick_corner(style, FRAME_W), pick_corner(style, FRAME_H));
  endtask

  // mixed writes and reads, a few positions beyond the frame
  task automatic random_traffic(input int count);
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) begin
        x = X_W'($urandom_range(0, X_MAX));
        y = Y_W'($urandom_range(0, Y_MAX));
      end else begin
        x = X_W'($urandom_range(0, FRAME_W - 1));
        y = Y_W'($urandom_range(0, FRAME_H - 1));
      end
      if ($urandom_range(0, 9) < 4)
        send_word(CMD_WRITE, x, y, PIX_W'($urandom_range(0, 255)));
      else
        read_sample(x, y, 1'b1);
    end
  endtask

  // corners are zero after reset, so every read lands on the origin
  task automatic test_reset_corners();
    read_sample(X_W'(X_MAX), Y_W'(Y_MAX), 1'b0);
  endtask

  // writes to indexes past the corner registers change nothing
  task automatic test_unused_index();
    wait_drained();
    write_reg(REG_UNUSED_LO, CFG_DATA_W'(DATA_MAX));
    write_reg(REG_UNUSED_HI, CFG_DATA_W'(10'h2aa));
    read_sample(X_W'(320), Y_W'(240), 1'b0);
  endtask

  // writes outside the frame must not alias into it
  task automatic test_dropped_writes();
    set_quad(10'd0, 10'd1, 10'd0, 10'd1, 10'd0, 10'd1, 10'd0, 10'd1);
    send_word(CMD_WRITE, X_W'(0), Y_W'(1), 8'hff);
    send_word(CMD_WRITE, X_W'(FRAME_W), Y_W'(0), 8'h00);
    send_word(CMD_WRITE, X_W'(0), Y_W'(FRAME_H), 8'h55);
    send_word(CMD_WRITE, X_W'(X_MAX), Y_W'(Y_MAX), 8'haa);
    send_word(CMD_READ, X_W'(17), Y_W'(33), 8'h00);
  endtask

  // full-frame quad, corner positions and saturated output positions
  task automatic test_frame_edges();
    set_quad(10'd0, 10'd0, 10'd639, 10'd0, 10'd639, 10'd479, 10'd0, 10'd479);
    send_word(CMD_WRITE, X_W'(0), Y_W'(0), 8'h00);
    send_word(CMD_WRITE, X_W'(FRAME_W - 1), Y_W'(FRAME_H - 1), 8'hff);
    read_sample(X_W'(0), Y_W'(0), 1'b0);
    read_sample(X_W'(FRAME_W - 1), Y_W'(FRAME_H - 1), 1'b0);
    read_sample(X_W'(X_MAX), Y_W'(Y_MAX), 1'b0);
    read_sample(X_W'(FRAME_W), Y_W'(0), 1'b0);
  endtask

  // sources past the frame in x, in y and in both
  task automatic test_clamped_source();
    set_quad(10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff);
    read_sample(X_W'(0), Y_W'(0), 1'b0);
    set_quad(10'd640, 10'd0, 10'd640, 10'd0, 10'd640, 10'd0, 10'd640, 10'd0);
    read_sample(X_W'(100), Y_W'(100), 1'b0);
    set_quad(10'd0, 10'd480, 10'd0, 10'd480, 10'd0, 10'd480, 10'd0, 10'd480);
    read_sample(X_W'(300), Y_W'(200), 1'b0);
  endtask

  task automatic test_random_quads();
    for (int phase = 0; phase < 6; phase++) begin
      program_random_quad(phase % 3);
      random_traffic(75);
    end
  endtask

  // long receiver hold while words keep coming, then a full drain
  task automatic test_full_output_queue();
    program_random_quad(0);
    tx_gaps_on = 1'b0;
    rx_hold_cycles = LONG_HOLD;
    random_traffic(80);
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  // back-to-back words with no idling on either side
  task automatic test_clean_stream();
    program_random_quad(0);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    random_traffic(100);
  endtask

  // receiver stall: long hold first, then random bursts
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      out_stall_i = 1'b1;
      rx_hold_cycles--;
    end else if (rx_burst > 0) begin
      out_stall_i = 1'b1;
      rx_burst--;
    end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall_i = 1'b1;
      rx_burst = $urandom_range(0, 4);
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // compare each result word with the oldest predicted sample
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result pix=%0d src=(%0d,%0d) clip=%0b",
                   $realtime, pixel_out_o, src_x_o, src_y_o, clipped_o);
      end else begin
        want = expected_samples.pop_front();
        results_checked++;
        if (pixel_out_o !== want.pix || src_x_o !== want.src_x ||
            src_y_o !== want.src_y || clipped_o !== want.clip) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp pix=%0d src=(%0d,%0d) clip=%0b, got pix=%0d src=(%0d,%0d) clip=%0b",
                     $realtime, want.pix, want.src_x, want.src_y, want.clip,
                     pixel_out_o, src_x_o, src_y_o, clipped_o);
        end
      end
    end
  end

  // watchdog on cycles where no word moves on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d samples outstanding",
               $realtime, QUIET_LIMIT, expected_samples.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      corner_x[i] = '0;
      corner_y[i] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    test_reset_corners();
    test_unused_index();
    test_dropped_writes();
    test_frame_edges();
    test_clamped_source();
    test_random_quads();
    test_full_output_queue();
    test_clean_stream();
    wait_drained();
    $display("Covered %0d reads (%0d clamped) and %0d stored plus %0d dropped pixel writes,",
             reads_sent, clipped_reads, writes_stored, writes_dropped);
    $display("over %0d quad settings and %0d register writes; %0d results checked, %0d bad.",
             quad_settings, reg_writes, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bqws_pkg.sv
rtl/bqws_fifo.sv
rtl/bqws_front.sv
rtl/bqws_back.sv
rtl/bilinear_quad_warp_sampler_unit.sv
bench/tb.sv
